// ===== rtl/core/prlbp_pkg.sv =====
`default_nettype none

package prlbp_pkg;

    // Frame decoding limits
    localparam int MAX_RUN_BITS  = 8;
    localparam int RESYNC_WORDS  = 4;
    localparam int DURATION_BITS = 15;

    // Field and internal widths
    localparam int BYTE_W  = 8;
    localparam int CUR_W   = 3;
    localparam int KIND_W  = 2;
    localparam int VALID_W = 4;
    localparam int CFG_W   = 15;
    localparam int RUN_W   = $clog2(MAX_RUN_BITS + 1);
    localparam int WIDX_W  = $clog2(RESYNC_WORDS + 1);
    localparam int HI_W    = CFG_W + 1;
    localparam int PROD_W  = HI_W + RUN_W;
    localparam int SUM_W   = RUN_W + 1;
    localparam int COMB_W  = BYTE_W + MAX_RUN_BITS;

    // Queue depths
    localparam int CLS_DEPTH = 2;
    localparam int RES_DEPTH = 2;
    localparam int CLS_PTR_W = $clog2(CLS_DEPTH);
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int CLS_CNT_W = $clog2(CLS_DEPTH + 1);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Configuration port
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_BIT_TIME  = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    localparam logic [CFG_W-1:0] BIT_TIME_RESET  = CFG_W'(256);
    localparam logic [CFG_W-1:0] TOLERANCE_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] LO_RESET = BIT_TIME_RESET - TOLERANCE_RESET;
    localparam logic [HI_W-1:0]  HI_RESET = HI_W'(BIT_TIME_RESET) + HI_W'(TOLERANCE_RESET);

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic                     first_word;
        logic                     level_a;
        logic [DURATION_BITS-1:0] duration_a;
        logic                     level_b;
        logic [DURATION_BITS-1:0] duration_b;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [KIND_W-1:0]  kind;
        logic [VALID_W-1:0] valid_bits;
        logic               last;
    } t_out_item;

    // Classified word: run lengths already matched, zero means no match
    typedef struct packed {
        logic             first_word;
        logic             level_a;
        logic [RUN_W-1:0] run_a;
        logic             level_b;
        logic [RUN_W-1:0] run_b;
        logic             end_b;
    } t_cls_item;

    typedef enum logic {
        ST_RUN_A,
        ST_RUN_B
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/core/prlbp_cfg.sv =====
`default_nettype none

module prlbp_cfg (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [prlbp_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [prlbp_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [prlbp_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                        pready,
    output logic      [prlbp_pkg::CFG_W-1:0]            o_lo,
    output logic      [prlbp_pkg::HI_W-1:0]             o_hi
);

    logic [prlbp_pkg::CFG_W-1:0] r_bit_time, n_bit_time;
    logic [prlbp_pkg::CFG_W-1:0] r_tol, n_tol;
    logic [prlbp_pkg::CFG_W-1:0] r_lo, n_lo;
    logic [prlbp_pkg::HI_W-1:0]  r_hi, n_hi;
    logic                        w_wr;
    logic                        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[prlbp_pkg::REG_IDX_BIT];

    // Decode the write and precompute the window bounds
    always_comb begin
        n_bit_time = r_bit_time;
        n_tol      = r_tol;
        if (w_wr) begin
            unique case (w_idx)
                prlbp_pkg::REG_BIT_TIME:  n_bit_time = pwdata[prlbp_pkg::CFG_W-1:0];
                prlbp_pkg::REG_TOLERANCE: n_tol      = pwdata[prlbp_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
        n_lo = (n_bit_time > n_tol) ? (n_bit_time - n_tol) : '0;
        n_hi = prlbp_pkg::HI_W'(n_bit_time) + prlbp_pkg::HI_W'(n_tol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_time <= prlbp_pkg::BIT_TIME_RESET;
            r_tol      <= prlbp_pkg::TOLERANCE_RESET;
            r_lo       <= prlbp_pkg::LO_RESET;
            r_hi       <= prlbp_pkg::HI_RESET;
        end else begin
            r_bit_time <= n_bit_time;
            r_tol      <= n_tol;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
        end
    end

    // Read back the stored register
    always_comb begin
        unique case (w_idx)
            prlbp_pkg::REG_BIT_TIME:  prdata = prlbp_pkg::APB_DATA_W'(r_bit_time);
            prlbp_pkg::REG_TOLERANCE: prdata = prlbp_pkg::APB_DATA_W'(r_tol);
            default:                  prdata = '0;
        endcase
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

`default_nettype wire

// ===== rtl/core/prlbp_front.sv =====
`default_nettype none

module prlbp_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire prlbp_pkg::t_in_item             i_item,
    output logic                                 o_full,
    input  wire logic [prlbp_pkg::CFG_W-1:0]     i_lo,
    input  wire logic [prlbp_pkg::HI_W-1:0]      i_hi,
    output logic                                 o_cls_valid,
    output prlbp_pkg::t_cls_item                 o_cls,
    input  wire logic                            i_cls_pop
);

    // Smallest run length k whose window lo*k < d < hi*k holds, zero if none
    function automatic logic [prlbp_pkg::RUN_W-1:0] run_length(
        input logic [prlbp_pkg::DURATION_BITS-1:0] d,
        input logic [prlbp_pkg::CFG_W-1:0]         lo,
        input logic [prlbp_pkg::HI_W-1:0]          hi
    );
        logic [prlbp_pkg::PROD_W-1:0] d_x;
        logic [prlbp_pkg::PROD_W-1:0] lo_k;
        logic [prlbp_pkg::PROD_W-1:0] hi_k;
        logic [prlbp_pkg::RUN_W-1:0]  k_sel;
        begin
            k_sel = '0;
            d_x   = prlbp_pkg::PROD_W'(d);
            for (int k = prlbp_pkg::MAX_RUN_BITS; k >= 1; k--) begin
                lo_k = prlbp_pkg::PROD_W'(lo) * prlbp_pkg::PROD_W'(k);
                hi_k = prlbp_pkg::PROD_W'(hi) * prlbp_pkg::PROD_W'(k);
                if (d_x < hi_k && d_x > lo_k) begin
                    k_sel = prlbp_pkg::RUN_W'(k);
                end
            end
            return k_sel;
        end
    endfunction

    prlbp_pkg::t_cls_item                r_mem [prlbp_pkg::CLS_DEPTH];
    logic [prlbp_pkg::CLS_PTR_W-1:0]     r_wptr, n_wptr;
    logic [prlbp_pkg::CLS_PTR_W-1:0]     r_rptr, n_rptr;
    logic [prlbp_pkg::CLS_CNT_W-1:0]     r_count, n_count;
    prlbp_pkg::t_cls_item                w_cls;
    logic                                w_wr;
    logic                                w_rd;

    // Classify the incoming word
    always_comb begin
        w_cls.first_word = i_item.first_word;
        w_cls.level_a    = i_item.level_a;
        w_cls.run_a      = run_length(i_item.duration_a, i_lo, i_hi);
        w_cls.level_b    = i_item.level_b;
        w_cls.run_b      = run_length(i_item.duration_b, i_lo, i_hi);
        w_cls.end_b      = (i_item.duration_b == '0);
    end

    assign o_full      = (r_count == prlbp_pkg::CLS_CNT_W'(prlbp_pkg::CLS_DEPTH));
    assign o_cls_valid = (r_count != '0);
    assign o_cls       = r_mem[r_rptr];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cls_pop && o_cls_valid;

    // Advance the queue pointers
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == prlbp_pkg::CLS_PTR_W'(prlbp_pkg::CLS_DEPTH - 1)) ?
                     '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == prlbp_pkg::CLS_PTR_W'(prlbp_pkg::CLS_DEPTH - 1)) ?
                     '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Hold the classified word until the back end takes it
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/prlbp_back.sv =====
`default_nettype none

module prlbp_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cls_valid,
    input  wire prlbp_pkg::t_cls_item  i_cls,
    output logic                       o_cls_pop,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output prlbp_pkg::t_out_item       o_res
);

    prlbp_pkg::t_back_state            r_state, n_state;
    logic [prlbp_pkg::BYTE_W-1:0]      r_acc, n_acc;
    logic [prlbp_pkg::CUR_W-1:0]       r_cur, n_cur;
    logic [prlbp_pkg::WIDX_W-1:0]      r_widx, n_widx;
    logic                              r_done, n_done;
    logic                              r_skip, n_skip;

    logic                              w_step;
    logic                              w_first;
    logic [prlbp_pkg::BYTE_W-1:0]      w_acc0;
    logic [prlbp_pkg::CUR_W-1:0]       w_cur0;
    logic [prlbp_pkg::WIDX_W-1:0]      w_widx0;
    logic                              w_done0;
    logic                              w_skip0;
    logic                              w_early;
    logic [prlbp_pkg::WIDX_W-1:0]      w_widx_inc;
    logic                              w_skip_word;

    logic                              w_sh_level;
    logic [prlbp_pkg::RUN_W-1:0]       w_sh_run;
    logic [prlbp_pkg::COMB_W-1:0]      w_sh_ones;
    logic [prlbp_pkg::COMB_W-1:0]      w_sh_comb;
    logic [prlbp_pkg::SUM_W-1:0]       w_sh_total;
    logic [prlbp_pkg::SUM_W-1:0]       w_sh_rem;
    logic                              w_sh_emit;
    logic [prlbp_pkg::BYTE_W-1:0]      w_sh_byte;
    logic [prlbp_pkg::BYTE_W-1:0]      w_sh_acc;
    logic [prlbp_pkg::CUR_W-1:0]       w_sh_cur;
    logic [prlbp_pkg::SUM_W-1:0]       w_b_total;
    logic                              w_b_emit;

    assign w_step = i_cls_valid && !i_res_full;

    // A first word restarts the frame before the word is decoded
    assign w_first  = (r_state == prlbp_pkg::ST_RUN_A) && i_cls.first_word;
    assign w_acc0   = w_first ? '0 : r_acc;
    assign w_cur0   = w_first ? '0 : r_cur;
    assign w_widx0  = w_first ? '0 : r_widx;
    assign w_done0  = w_first ? 1'b0 : r_done;
    assign w_skip0  = w_first ? 1'b0 : r_skip;

    assign w_early     = (w_widx0 < prlbp_pkg::WIDX_W'(prlbp_pkg::RESYNC_WORDS));
    assign w_widx_inc  = w_early ? (w_widx0 + 1'b1) : w_widx0;
    assign w_skip_word = w_skip0 && w_early;

    // Shared run shifter: append k copies of the level, split off a full byte
    assign w_sh_level = (r_state == prlbp_pkg::ST_RUN_A) ? i_cls.level_a : i_cls.level_b;
    assign w_sh_run   = (r_state == prlbp_pkg::ST_RUN_A) ? i_cls.run_a : i_cls.run_b;

    always_comb begin
        w_sh_ones  = w_sh_level ?
                     ((prlbp_pkg::COMB_W'(1) << w_sh_run) - prlbp_pkg::COMB_W'(1)) : '0;
        w_sh_comb  = (prlbp_pkg::COMB_W'(w_acc0) << w_sh_run) | w_sh_ones;
        w_sh_total = prlbp_pkg::SUM_W'(w_cur0) + prlbp_pkg::SUM_W'(w_sh_run);
        w_sh_emit  = (w_sh_total >= prlbp_pkg::SUM_W'(prlbp_pkg::BYTE_W));
        w_sh_rem   = w_sh_total - prlbp_pkg::SUM_W'(prlbp_pkg::BYTE_W);
        if (w_sh_emit) begin
            w_sh_byte = prlbp_pkg::BYTE_W'(w_sh_comb >> w_sh_rem);
            w_sh_acc  = prlbp_pkg::BYTE_W'(w_sh_comb &
                        ((prlbp_pkg::COMB_W'(1) << w_sh_rem) - prlbp_pkg::COMB_W'(1)));
            w_sh_cur  = w_sh_rem[prlbp_pkg::CUR_W-1:0];
        end else begin
            w_sh_byte = w_sh_comb[prlbp_pkg::BYTE_W-1:0];
            w_sh_acc  = w_sh_comb[prlbp_pkg::BYTE_W-1:0];
            w_sh_cur  = w_sh_total[prlbp_pkg::CUR_W-1:0];
        end
    end

    // Look ahead: does the second half of this word give a result too
    assign w_b_total = prlbp_pkg::SUM_W'(w_sh_cur) + prlbp_pkg::SUM_W'(i_cls.run_b);
    always_comb begin
        if (i_cls.run_b != '0) begin
            w_b_emit = (w_b_total >= prlbp_pkg::SUM_W'(prlbp_pkg::BYTE_W));
        end else if (i_cls.end_b) begin
            w_b_emit = 1'b1;
        end else begin
            w_b_emit = !w_early;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prlbp_pkg::ST_RUN_A: begin
                if (w_step && !w_done0 && !w_skip_word && (i_cls.run_a != '0)) begin
                    n_state = prlbp_pkg::ST_RUN_B;
                end
            end
            prlbp_pkg::ST_RUN_B: begin
                if (w_step) begin
                    n_state = prlbp_pkg::ST_RUN_A;
                end
            end
            default: n_state = prlbp_pkg::ST_RUN_A;
        endcase
    end

    // Outputs and decoder state updates
    always_comb begin
        n_acc      = r_acc;
        n_cur      = r_cur;
        n_widx     = r_widx;
        n_done     = r_done;
        n_skip     = r_skip;
        o_cls_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            prlbp_pkg::ST_RUN_A: begin
                if (w_step) begin
                    n_acc  = w_acc0;
                    n_cur  = w_cur0;
                    n_widx = w_widx0;
                    n_done = w_done0;
                    n_skip = w_skip0;
                    if (w_done0) begin
                        o_cls_pop = 1'b1;
                    end else if (w_skip_word) begin
                        n_widx    = w_widx_inc;
                        o_cls_pop = 1'b1;
                    end else begin
                        n_skip = 1'b0;
                        if (i_cls.run_a == '0) begin
                            n_widx    = w_widx_inc;
                            o_cls_pop = 1'b1;
                            if (w_early) begin
                                n_acc  = '0;
                                n_cur  = '0;
                                n_skip = 1'b1;
                            end else begin
                                n_done     = 1'b1;
                                o_res_push = 1'b1;
                                o_res.kind = prlbp_pkg::KIND_ERROR;
                                o_res.last = 1'b1;
                            end
                        end else begin
                            n_acc = w_sh_acc;
                            n_cur = w_sh_cur;
                            if (w_sh_emit) begin
                                o_res_push       = 1'b1;
                                o_res.data_byte  = w_sh_byte;
                                o_res.kind       = prlbp_pkg::KIND_DATA;
                                o_res.valid_bits = prlbp_pkg::VALID_W'(prlbp_pkg::BYTE_W);
                                o_res.last       = !w_b_emit;
                            end
                        end
                    end
                end
            end
            prlbp_pkg::ST_RUN_B: begin
                if (w_step) begin
                    o_cls_pop = 1'b1;
                    n_widx    = w_widx_inc;
                    if (i_cls.run_b != '0) begin
                        n_acc = w_sh_acc;
                        n_cur = w_sh_cur;
                        if (w_sh_emit) begin
                            o_res_push       = 1'b1;
                            o_res.data_byte  = w_sh_byte;
                            o_res.kind       = prlbp_pkg::KIND_DATA;
                            o_res.valid_bits = prlbp_pkg::VALID_W'(prlbp_pkg::BYTE_W);
                            o_res.last       = 1'b1;
                        end
                    end else if (i_cls.end_b) begin
                        n_acc            = {r_acc[prlbp_pkg::BYTE_W-2:0], i_cls.level_b};
                        n_done           = 1'b1;
                        o_res_push       = 1'b1;
                        o_res.data_byte  = {r_acc[prlbp_pkg::BYTE_W-2:0], i_cls.level_b};
                        o_res.kind       = prlbp_pkg::KIND_PARTIAL;
                        o_res.valid_bits = prlbp_pkg::VALID_W'(r_cur) + 1'b1;
                        o_res.last       = 1'b1;
                    end else if (w_early) begin
                        n_acc  = '0;
                        n_cur  = '0;
                        n_skip = 1'b1;
                    end else begin
                        n_done     = 1'b1;
                        o_res_push = 1'b1;
                        o_res.kind = prlbp_pkg::KIND_ERROR;
                        o_res.last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prlbp_pkg::ST_RUN_A;
            r_acc   <= '0;
            r_cur   <= '0;
            r_widx  <= '0;
            r_done  <= 1'b1;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_cur   <= n_cur;
            r_widx  <= n_widx;
            r_done  <= n_done;
            r_skip  <= n_skip;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_second_half_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prlbp_pkg::ST_RUN_B) |-> i_cls_valid)
        else $error("second half decoded without a held word");

    a_error_stops_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && (o_res.kind == prlbp_pkg::KIND_ERROR)) |=> r_done)
        else $error("frame not stopped after a decode error");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/prlbp_outq.sv =====
`default_nettype none

module prlbp_outq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire prlbp_pkg::t_out_item  i_res,
    output logic                       o_full,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output prlbp_pkg::t_out_item       o_res
);

    prlbp_pkg::t_out_item              r_mem [prlbp_pkg::RES_DEPTH];
    logic [prlbp_pkg::RES_PTR_W-1:0]   r_wptr, n_wptr;
    logic [prlbp_pkg::RES_PTR_W-1:0]   r_rptr, n_rptr;
    logic [prlbp_pkg::RES_CNT_W-1:0]   r_count, n_count;
    logic                              w_wr;
    logic                              w_rd;

    assign o_full  = (r_count == prlbp_pkg::RES_CNT_W'(prlbp_pkg::RES_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_res   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Advance the queue pointers
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == prlbp_pkg::RES_PTR_W'(prlbp_pkg::RES_DEPTH - 1)) ?
                     '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == prlbp_pkg::RES_PTR_W'(prlbp_pkg::RES_DEPTH - 1)) ?
                     '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Hold each result until the consumer takes the transaction
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_res;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= prlbp_pkg::RES_CNT_W'(prlbp_pkg::RES_DEPTH)) &&
        ((r_count == '0) || (r_wptr != r_rptr) || o_full))
        else $error("result queue count out of step with its pointers");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pulse_run_length_bit_packer.sv =====
// Throughput: a word's second half is decoded in the sequencer state after its first half, and
// the word is popped only then; a word dropped or failed in its first half goes one per cycle
// while the result queue has room. The back-end sequencer decodes one half and writes at most
// one result a cycle.
// Reset: synchronous, active low; clears both queues and the decoder state (idle until a
// first word) and restores bit time 256 and tolerance 64. No clearing pass.
`default_nettype none

module pulse_run_length_bit_packer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire prlbp_pkg::t_in_item                i_data,
    output logic                                    empty,
    input  wire logic                               pop,
    output prlbp_pkg::t_out_item                    o_data,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [prlbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [prlbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [prlbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                    pready
);

    logic [prlbp_pkg::CFG_W-1:0] w_lo;
    logic [prlbp_pkg::HI_W-1:0]  w_hi;
    logic                        w_cls_valid;
    prlbp_pkg::t_cls_item        w_cls;
    logic                        w_cls_pop;
    logic                        w_res_full;
    logic                        w_res_push;
    prlbp_pkg::t_out_item        w_res;

    // Configuration registers and match window bounds
    prlbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    // Accept and classify pulse words
    prlbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_data),
        .o_full      (full),
        .i_lo        (w_lo),
        .i_hi        (w_hi),
        .o_cls_valid (w_cls_valid),
        .o_cls       (w_cls),
        .i_cls_pop   (w_cls_pop)
    );

    // Pack runs into bytes
    prlbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (w_cls_valid),
        .i_cls       (w_cls),
        .o_cls_pop   (w_cls_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Queue results for the consumer
    prlbp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_data)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prlbp_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP     = 8;
    localparam int DRAIN_WAIT  = 4;
    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 155;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DUR_MAX     = (1 << DURATION_BITS) - 1;

    localparam logic [APB_ADDR_W-1:0] ADDR_BIT_TIME  = APB_ADDR_W'(REG_BIT_TIME) << REG_IDX_BIT;
    localparam logic [APB_ADDR_W-1:0] ADDR_TOLERANCE = APB_ADDR_W'(REG_TOLERANCE) << REG_IDX_BIT;

    // How a transaction's results are obtained: from the decoder copy, typed in, or none expected
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } t_chk;

    typedef struct packed {
        t_in_item  word;
        t_chk      mode;
        t_out_item result;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in_item i_data = '0;
    logic empty;
    logic pop = 1'b0;
    t_out_item o_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Sideband travelling with each input transaction
    t_chk row_mode = CHK_MODEL;
    t_out_item row_result = '0;

    // Decoder copy: configuration and frame state
    logic [CFG_W-1:0]   cfg_bit_time = BIT_TIME_RESET;
    logic [CFG_W-1:0]   cfg_tolerance = TOLERANCE_RESET;
    logic [BYTE_W-1:0]  acc_byte = '0;
    logic [CUR_W-1:0]   acc_bits = '0;
    logic [WIDX_W-1:0]  word_pos = '0;
    logic               frame_idle = 1'b1;
    logic               resyncing = 1'b0;

    t_out_item word_results[$];
    t_out_item owed_results[$];
    t_row dir_rows[$];
    int fail_count = 0;
    int unsigned cycle_count = 0;
    bit push_steady = 1'b0;
    bit pop_steady = 1'b0;

    pulse_run_length_bit_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Acceptance window for one bit time, lower edge clamped at zero
    function automatic void bit_window(output int lo, output int hi);
        lo = (cfg_bit_time > cfg_tolerance) ? int'(cfg_bit_time) - int'(cfg_tolerance) : 0;
        hi = int'(cfg_bit_time) + int'(cfg_tolerance);
    endfunction

    // Smallest run length whose window holds the duration, zero if none
    function automatic int match_run(input logic [DURATION_BITS-1:0] d);
        int lo, hi;
        bit_window(lo, hi);
        for (int k = 1; k <= MAX_RUN_BITS; k++) begin
            if (int'(d) < hi * k && int'(d) > lo * k) return k;
        end
        return 0;
    endfunction

    function automatic void emit(input logic [BYTE_W-1:0] b, input logic [KIND_W-1:0] k,
                                 input logic [VALID_W-1:0] n);
        t_out_item r;
        r.data_byte  = b;
        r.kind       = k;
        r.valid_bits = n;
        r.last       = 1'b0;
        word_results.push_back(r);
    endfunction

    // Shift a run of one level into the byte, emitting each full byte
    function automatic void shift_level(input logic lvl, input int run);
        for (int i = 0; i < run; i++) begin
            acc_byte = {acc_byte[BYTE_W-2:0], lvl};
            if (acc_bits == CUR_W'(BYTE_W - 1)) begin
                emit(acc_byte, KIND_DATA, VALID_W'(BYTE_W));
                acc_byte = '0;
                acc_bits = '0;
            end else begin
                acc_bits++;
            end
        end
    endfunction

    // Unmatched duration: resync early in the frame, error later on
    function automatic void reject_run();
        if (word_pos < RESYNC_WORDS) begin
            acc_byte  = '0;
            acc_bits  = '0;
            resyncing = 1'b1;
        end else begin
            emit('0, KIND_ERROR, '0);
            frame_idle = 1'b1;
        end
    endfunction

    // Decode one pulse word into word_results and advance the frame state
    function automatic void decode_word(input t_in_item w);
        int run;
        word_results.delete();
        if (w.first_word) begin
            acc_byte   = '0;
            acc_bits   = '0;
            word_pos   = '0;
            frame_idle = 1'b0;
            resyncing  = 1'b0;
        end
        if (frame_idle) return;
        if (resyncing && word_pos < RESYNC_WORDS) begin
            word_pos++;
            return;
        end
        resyncing = 1'b0;
        run = match_run(w.duration_a);
        if (run == 0) begin
            reject_run();
        end else begin
            shift_level(w.level_a, run);
            run = match_run(w.duration_b);
            if (run != 0) begin
                shift_level(w.level_b, run);
            end else if (w.duration_b == '0) begin
                acc_byte = {acc_byte[BYTE_W-2:0], w.level_b};
                emit(acc_byte, KIND_PARTIAL, VALID_W'(acc_bits) + VALID_W'(1));
                frame_idle = 1'b1;
            end else begin
                reject_run();
            end
        end
        if (word_pos < RESYNC_WORDS) word_pos++;
        if (word_results.size() > 0) word_results[word_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (owed_results.size() == 0) begin
            $error("result with nothing owed: data_byte %02h kind %0d", got.data_byte, got.kind);
            fail_count++;
            return;
        end
        want = owed_results.pop_front();
        if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
            fail_count++;
        end
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
        end
        if (got.valid_bits !== want.valid_bits) begin
            $error("valid_bits: expected %0d, got %0d", want.valid_bits, got.valid_bits);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fail_count++;
        end
    endfunction

    function automatic int draw_gap(inout bit steady);
        if ($urandom_range(31, 0) == 0) steady = !steady;
        return steady ? 0 : $urandom_range(MAX_GAP, 0);
    endfunction

    function automatic logic [DURATION_BITS-1:0] noise_ticks();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return DURATION_BITS'(DUR_MAX);
            2: return DURATION_BITS'(1);
            default: return DURATION_BITS'($urandom_range(DUR_MAX, 0));
        endcase
    endfunction

    // Duration that lands inside the window of a random run length, or noise if that window is empty
    function automatic logic [DURATION_BITS-1:0] pulse_ticks();
        int lo, hi, k, lo_k, hi_k;
        bit_window(lo, hi);
        k = $urandom_range(MAX_RUN_BITS, 1);
        lo_k = lo * k + 1;
        hi_k = (hi * k - 1 > DUR_MAX) ? DUR_MAX : hi * k - 1;
        if (lo_k > hi_k) return noise_ticks();
        return DURATION_BITS'($urandom_range(hi_k, lo_k));
    endfunction

    function automatic t_row mk(input logic fw, la, input logic [DURATION_BITS-1:0] da,
                                input logic lb, input logic [DURATION_BITS-1:0] db,
                                input t_chk mode, input logic [BYTE_W-1:0] eb = '0,
                                input logic [KIND_W-1:0] ek = KIND_DATA,
                                input logic [VALID_W-1:0] ev = '0);
        t_row r;
        r.word.first_word  = fw;
        r.word.level_a     = la;
        r.word.duration_a  = da;
        r.word.level_b     = lb;
        r.word.duration_b  = db;
        r.mode             = mode;
        r.result.data_byte = eb;
        r.result.kind      = ek;
        r.result.valid_bits = ev;
        r.result.last      = 1'b1;
        return r;
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(input t_in_item w, input t_chk mode, input t_out_item res);
        int gap;
        gap = draw_gap(push_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_data     <= w;
        row_mode   <= mode;
        row_result <= res;
        push       <= 1'b1;
        do @(posedge i_clk); while (full !== 1'b0);
    endtask

    // Write a register, then read it back
    task automatic set_reg(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(value)) begin
            $error("prdata at %0h: expected %0h, got %0h", addr, APB_DATA_W'(value), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content, the rest noise
    task automatic run_random(input int quota);
        int sent, words;
        t_in_item w;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99, 0) < 80) begin
                words = $urandom_range(9, 1);
                for (int i = 0; i < words; i++) begin
                    w.first_word = (i == 0);
                    w.level_a    = $urandom_range(1, 0);
                    w.duration_a = pulse_ticks();
                    w.level_b    = $urandom_range(1, 0);
                    w.duration_b = pulse_ticks();
                    if (i == words - 1 && $urandom_range(9, 0) != 0) w.duration_b = '0;
                    if ($urandom_range(19, 0) == 0) w.duration_a = noise_ticks();
                    if ($urandom_range(19, 0) == 0) w.duration_b = noise_ticks();
                    send_word(w, CHK_MODEL, '0);
                    sent++;
                end
            end else begin
                w.first_word = ($urandom_range(3, 0) == 0);
                w.level_a    = $urandom_range(1, 0);
                w.duration_a = noise_ticks();
                w.level_b    = $urandom_range(1, 0);
                w.duration_b = noise_ticks();
                if (w.first_word || !frame_idle) sent++;
                send_word(w, CHK_MODEL, '0);
            end
        end
        push <= 1'b0;
    endtask

    // Predict on accepted words, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                decode_word(i_data);
                case (row_mode)
                    CHK_MODEL: foreach (word_results[i]) owed_results.push_back(word_results[i]);
                    CHK_ONE:   owed_results.push_back(row_result);
                    default:   ;
                endcase
            end
            if (pop && !empty) check_result(o_data);
        end
    end

    // Drain results with random stalls
    initial begin : result_drain
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap(pop_steady);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] bt, tl;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at the reset configuration (window 193..319 per bit)
        dir_rows = '{
            mk(0, 1, 256, 1, 256, CHK_NONE),
            mk(1, 1, 256, 0, 0, CHK_ONE, 8'h02, KIND_PARTIAL, 4'd2),
            mk(0, 1, 256, 1, 256, CHK_NONE),
            mk(1, 1, 2048, 0, 0, CHK_ONE, 8'hFE, KIND_PARTIAL, 4'd8),
            mk(1, 1, 2500, 0, 2500, CHK_MODEL),
            mk(0, 0, 32767, 1, 1, CHK_NONE),
            mk(0, 1, 256, 1, 256, CHK_NONE),
            mk(0, 1, 256, 1, 256, CHK_NONE),
            mk(0, 1, 319, 0, 193, CHK_MODEL),
            mk(0, 1, 320, 0, 0, CHK_ONE, 8'h00, KIND_ERROR, 4'd0),
            mk(1, 0, 0, 0, 0, CHK_NONE),
            mk(0, 1, 192, 1, 256, CHK_NONE),
            mk(0, 0, 32767, 0, 32767, CHK_NONE),
            mk(0, 1, 1, 1, 0, CHK_NONE),
            mk(0, 1, 1, 1, 256, CHK_ONE, 8'h00, KIND_ERROR, 4'd0),
            mk(1, 1, 2500, 0, 100, CHK_MODEL),
            mk(1, 1, 256, 1, 256, CHK_MODEL),
            mk(0, 0, 256, 1, 256, CHK_MODEL),
            mk(0, 1, 256, 0, 256, CHK_MODEL),
            mk(0, 0, 256, 0, 256, CHK_MODEL),
            mk(0, 1, 256, 0, 5, CHK_ONE, 8'h00, KIND_ERROR, 4'd0),
            mk(1, 1, 639, 0, 0, CHK_MODEL)
        };
        foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].mode, dir_rows[i].result);
        push <= 1'b0;

        // Random phases, each with the bit time and tolerance written first
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                1: begin bt = 1;     tl = 0;     end
                3: begin bt = 32766; tl = 32766; end
                5: begin bt = 1;     tl = 32766; end
                6: begin bt = 32766; tl = 0;     end
                0, 8: begin bt = BIT_TIME_RESET; tl = TOLERANCE_RESET; end
                default: begin
                    bt = CFG_W'($urandom_range(3000, 20));
                    tl = CFG_W'($urandom_range(bt / 2, 0));
                end
            endcase
            set_reg(ADDR_BIT_TIME, bt);
            set_reg(ADDR_TOLERANCE, tl);
            cfg_bit_time  = bt;
            cfg_tolerance = tl;
            @(posedge i_clk);
            run_random(PHASE_WORDS);
        end

        wait_drained();
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
